// File: hdl/suffixient_sample_scan_macros.svh
// Assertion helpers used by the top-level RTL file.
`ifndef SUFFIXIENT_SAMPLE_SCAN_MACROS_SVH
`define SUFFIXIENT_SAMPLE_SCAN_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SSS_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sss: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define SSS_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sss: next-cycle check failed");

`endif

// File: hdl/sss_pkg.sv
`timescale 1ns / 1ps
package sss_pkg;
	localparam int SSS_ALPHABET = 64;
	localparam int SSS_POS_BITS = 32;

	// register index, taken from paddr[2]
	localparam logic REG_TEXT_LENGTH   = 1'b0;
	localparam logic REG_ALPHABET_SIZE = 1'b1;

	typedef struct packed {
		logic accept;
		logic rd;
		logic ev;
		logic raise_rd;
		logic raise_wr;
		logic fin;
	} sss_cmd_t;

	typedef struct packed {
		logic start_scan;
		logic scan_done;
		logic flush;
		logic emit;
		logic pend_vld;
		logic out_free;
		logic raise_sel;
	} sss_sts_t;
endpackage

// File: hdl/sss_ram.sv
`timescale 1ns / 1ps
module sss_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

// File: hdl/sss_ctrl.sv
`timescale 1ns / 1ps
module sss_ctrl
	import sss_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  sss_sts_t sts,
	output sss_cmd_t cmd
);
	typedef enum logic [5:0] {
		S_IDLE     = 6'b000001,
		S_RD       = 6'b000010,
		S_EV       = 6'b000100,
		S_RAISE_RD = 6'b001000,
		S_RAISE_EV = 6'b010000,
		S_FIN      = 6'b100000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					if (sts.start_scan) begin
						state_d = S_RD;
					end
				end
			end
			S_RD: begin
				if (sts.scan_done) begin
					state_d = sts.flush ? S_FIN : S_RAISE_RD;
				end else begin
					cmd.rd  = 1'b1;
					state_d = S_EV;
				end
			end
			S_EV: begin
				// a second sample pushes the held one out, so that needs room
				if (!(sts.emit && sts.pend_vld && !sts.out_free)) begin
					cmd.ev  = 1'b1;
					state_d = S_RD;
				end
			end
			S_RAISE_RD: begin
				cmd.raise_rd = 1'b1;
				state_d      = S_RAISE_EV;
			end
			S_RAISE_EV: begin
				cmd.raise_wr = 1'b1;
				state_d      = sts.raise_sel ? S_FIN : S_RAISE_RD;
			end
			S_FIN: begin
				if (!(sts.pend_vld && !sts.out_free)) begin
					cmd.fin = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end
endmodule

// File: hdl/sss_dp.sv
`timescale 1ns / 1ps
module sss_dp
	import sss_pkg::*;
#(
	parameter int ALPHABET = SSS_ALPHABET,
	parameter int POS_BITS = SSS_POS_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [31:0] text_length,
	input  logic [6:0]  alphabet_size,
	input  logic        mode,
	input  logic [31:0] lcp_value,
	input  logic [5:0]  bwt_symbol,
	input  logic [31:0] sa_value,
	input  logic        out_ready,
	output logic        out_valid,
	output logic [31:0] sample_position,
	output logic [32:0] sample_length,
	output logic [5:0]  sample_symbol,
	output logic [31:0] symbol_multiplicity,
	output logic        last_of_run,
	input  sss_cmd_t    cmd,
	output sss_sts_t    sts
);
	localparam int AW = $clog2(ALPHABET);
	localparam int CW = $clog2(ALPHABET + 1);
	localparam int WW = 99 + POS_BITS;
	localparam int DW = (POS_BITS > 33) ? POS_BITS : 33;

	// item and scan state
	logic                item_flush_q;
	logic [31:0]         item_lcp_q;
	logic [5:0]          item_sym_q;
	logic [31:0]         item_sa_q;
	logic signed [32:0]  mval_q;
	logic [CW-1:0]       cnt_q;
	logic                raise_sel_q;
	logic [31:0]         min_q;
	logic                min_inf_q;
	logic [5:0]          prev_sym_q;
	logic [31:0]         prev_sa_q;
	logic                have_prev_q;
	logic [ALPHABET-1:0] vld_q;
	logic                vld_s1;

	// held sample and output register
	logic                pend_vld_q;
	logic [31:0]         pend_pos_q;
	logic [32:0]         pend_len_q;
	logic [5:0]          pend_sym_q;
	logic [31:0]         pend_cnt_q;
	logic                out_vld_q;
	logic [31:0]         out_pos_q;
	logic [32:0]         out_len_q;
	logic [5:0]          out_sym_q;
	logic [31:0]         out_cnt_q;
	logic                out_last_q;

	logic                we;
	logic [AW-1:0]       waddr;
	logic [WW-1:0]       wdata;
	logic                re;
	logic [AW-1:0]       raddr;
	logic [WW-1:0]       rdata;

	logic signed [32:0]  rec_len;
	logic [POS_BITS-1:0] rec_pos;
	logic signed [32:0]  rec_lcs;
	logic                rec_act;
	logic [31:0]         rec_cnt;
	logic [31:0]         cnt_inc;
	logic                hit;
	logic [6:0]          lim;
	logic [31:0]         new_min;
	logic [5:0]          rsym;
	logic [31:0]         rsa;
	logic                rgo;
	logic signed [32:0]  pdiff;
	logic [DW-1:0]       pdiff_x;
	logic [POS_BITS-1:0] rpos;
	logic [POS_BITS-1:0] pos_m1;
	logic                push_ev;
	logic                push_fin;
	logic                out_free;

	sss_ram #(.WIDTH(WW), .DEPTH(ALPHABET)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	// entries never written since reset or flush read as the cleared record
	always_comb begin
		if (vld_s1) begin
			rec_len = $signed(rdata[WW-1 -: 33]);
			rec_pos = rdata[66 +: POS_BITS];
			rec_lcs = $signed(rdata[65:33]);
			rec_act = rdata[32];
			rec_cnt = rdata[31:0];
		end else begin
			rec_len = -33'sd1;
			rec_pos = '0;
			rec_lcs = -33'sd1;
			rec_act = 1'b0;
			rec_cnt = '0;
		end
	end

	assign cnt_inc = rec_cnt + 32'd1;
	assign hit     = mval_q < rec_len;
	assign lim     = (alphabet_size > 7'(ALPHABET)) ? 7'(ALPHABET) : alphabet_size;
	assign new_min = (!min_inf_q && (min_q < lcp_value)) ? min_q : lcp_value;
	assign rsym    = raise_sel_q ? item_sym_q : prev_sym_q;
	assign rsa     = raise_sel_q ? item_sa_q : prev_sa_q;
	assign rgo     = (7'(rsym) < 7'(ALPHABET)) && ($signed({1'b0, item_lcp_q}) > rec_len);
	assign pdiff   = $signed({1'b0, text_length}) - $signed({1'b0, rsa});
	assign pdiff_x = DW'(pdiff);
	assign rpos    = pdiff_x[POS_BITS-1:0];
	assign pos_m1  = rec_pos - POS_BITS'(1);

	assign re    = cmd.rd | cmd.raise_rd;
	assign raddr = cmd.raise_rd ? rsym[AW-1:0] : cnt_q[AW-1:0];
	assign we    = (cmd.ev & hit) | (cmd.raise_wr & rgo);
	assign waddr = cmd.raise_wr ? rsym[AW-1:0] : cnt_q[AW-1:0];
	always_comb begin
		if (cmd.raise_wr) begin
			wdata = {{1'b0, item_lcp_q}, rpos, rec_lcs, 1'b1, rec_cnt};
		end else begin
			wdata = {mval_q, POS_BITS'(0), mval_q, 1'b0, (rec_act ? cnt_inc : rec_cnt)};
		end
	end

	assign out_free = !out_vld_q || out_ready;
	assign push_ev  = cmd.ev && hit && rec_act && pend_vld_q;
	assign push_fin = cmd.fin && pend_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q        <= '0;
			raise_sel_q  <= 1'b0;
			item_flush_q <= 1'b0;
			min_q        <= '0;
			min_inf_q    <= 1'b1;
			prev_sym_q   <= '0;
			prev_sa_q    <= '0;
			have_prev_q  <= 1'b0;
			vld_q        <= '0;
			vld_s1       <= 1'b0;
			pend_vld_q   <= 1'b0;
			out_vld_q    <= 1'b0;
		end else begin
			if (cmd.accept) begin
				cnt_q        <= CW'(1);
				raise_sel_q  <= 1'b0;
				item_flush_q <= mode;
				if (!mode) begin
					if (!have_prev_q) begin
						have_prev_q <= 1'b1;
						prev_sym_q  <= bwt_symbol;
						prev_sa_q   <= sa_value;
					end else if (bwt_symbol == prev_sym_q) begin
						min_q     <= new_min;
						min_inf_q <= 1'b0;
						prev_sa_q <= sa_value;
					end
				end
			end
			if (cmd.ev) begin
				cnt_q <= cnt_q + CW'(1);
			end
			if (cmd.raise_wr) begin
				raise_sel_q <= 1'b1;
			end
			if (re) begin
				vld_s1 <= vld_q[raddr];
			end
			if (we) begin
				vld_q[waddr] <= 1'b1;
			end
			if (cmd.ev && hit && rec_act) begin
				pend_vld_q <= 1'b1;
			end else if (cmd.fin) begin
				pend_vld_q <= 1'b0;
			end
			out_vld_q <= (out_vld_q && !out_ready) || push_ev || push_fin;
			if (cmd.fin) begin
				min_inf_q <= 1'b1;
				if (item_flush_q) begin
					vld_q       <= '0;
					prev_sym_q  <= '0;
					prev_sa_q   <= '0;
					have_prev_q <= 1'b0;
				end else begin
					prev_sym_q <= item_sym_q;
					prev_sa_q  <= item_sa_q;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			item_lcp_q <= lcp_value;
			item_sym_q <= bwt_symbol;
			item_sa_q  <= sa_value;
			mval_q     <= mode ? -33'sd1 : $signed({1'b0, new_min});
		end
		if (cmd.ev && hit && rec_act) begin
			pend_pos_q <= 32'(pos_m1);
			pend_len_q <= 33'(rec_lcs + 33'sd1);
			pend_sym_q <= 6'(cnt_q);
			pend_cnt_q <= cnt_inc;
		end
		if (push_ev || push_fin) begin
			out_pos_q  <= pend_pos_q;
			out_len_q  <= pend_len_q;
			out_sym_q  <= pend_sym_q;
			out_cnt_q  <= pend_cnt_q;
			out_last_q <= push_fin;
		end
	end

	assign out_valid           = out_vld_q;
	assign sample_position     = out_pos_q;
	assign sample_length       = out_len_q;
	assign sample_symbol       = out_sym_q;
	assign symbol_multiplicity = out_cnt_q;
	assign last_of_run         = out_last_q;

	assign sts.start_scan = mode || (have_prev_q && (bwt_symbol != prev_sym_q));
	assign sts.scan_done  = !(7'(cnt_q) < lim);
	assign sts.flush      = item_flush_q;
	assign sts.emit       = hit && rec_act;
	assign sts.pend_vld   = pend_vld_q;
	assign sts.out_free   = out_free;
	assign sts.raise_sel  = raise_sel_q;
endmodule

// File: hdl/suffixient_sample_scan.sv
`timescale 1ns / 1ps
// Suffixient sample scan. Feed suffix array entries in suffix order (mode 0) and
// a flush item (mode 1) at the end of the text; each sample comes out as one
// transaction, last_of_run marking the final one caused by an input item. An
// entry whose symbol matches the previous one, and the first entry, are taken
// without a scan. A symbol change is accepted, then gets a read and a write-back
// for each of symbols 1 to min(alphabet_size, ALPHABET)-1, a step to see the
// end of the walk, a read and a write for each of the two candidate raises and
// a finish step; a flush skips the raises. Output stalls can hold the walk and
// the finish. Write text_length and alphabet_size only while the block is idle.
`include "suffixient_sample_scan_macros.svh"
module suffixient_sample_scan
	import sss_pkg::*;
#(
	parameter int ALPHABET = SSS_ALPHABET,
	parameter int POS_BITS = SSS_POS_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        mode,
	input  logic [31:0] lcp_value,
	input  logic [5:0]  bwt_symbol,
	input  logic [31:0] sa_value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] sample_position,
	output logic [32:0] sample_length,
	output logic [5:0]  sample_symbol,
	output logic [31:0] symbol_multiplicity,
	output logic        last_of_run
);
	logic [31:0] text_length_q;
	logic [6:0]  alphabet_size_q;
	sss_cmd_t    cmd;
	sss_sts_t    sts;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_length_q   <= 32'd1;
			alphabet_size_q <= 7'd64;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				REG_TEXT_LENGTH:   text_length_q   <= pwdata;
				REG_ALPHABET_SIZE: alphabet_size_q <= pwdata[6:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_TEXT_LENGTH:   prdata = text_length_q;
			REG_ALPHABET_SIZE: prdata = {25'd0, alphabet_size_q};
			default:           prdata = '0;
		endcase
	end

	sss_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	sss_dp #(.ALPHABET(ALPHABET), .POS_BITS(POS_BITS)) u_dp (
		.clk                 (clk),
		.arst_n              (arst_n),
		.text_length         (text_length_q),
		.alphabet_size       (alphabet_size_q),
		.mode                (mode),
		.lcp_value           (lcp_value),
		.bwt_symbol          (bwt_symbol),
		.sa_value            (sa_value),
		.out_ready           (out_ready),
		.out_valid           (out_valid),
		.sample_position     (sample_position),
		.sample_length       (sample_length),
		.sample_symbol       (sample_symbol),
		.symbol_multiplicity (symbol_multiplicity),
		.last_of_run         (last_of_run),
		.cmd                 (cmd),
		.sts                 (sts)
	);

	`SSS_ASSERT_NXT(a_flush_busy, in_valid && in_ready && mode, !in_ready)
	`SSS_ASSERT_IMP(a_idle_no_pending, in_ready, !sts.pend_vld)
	`SSS_ASSERT_IMP(a_symbol_nonzero, out_valid, sample_symbol != 6'd0)
endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps
module testbench;
	import sss_pkg::*;

	localparam int NSYM = SSS_ALPHABET;
	localparam logic [33:0] LEN_INF = 34'h1_FFFF_FFFF;
	localparam logic [33:0] LEN_NONE = '1; // -1
	localparam logic MODE_ENTRY = 1'b0;
	localparam logic MODE_FLUSH = 1'b1;

	typedef struct packed {
		logic        mode;
		logic [31:0] lcp;
		logic [5:0]  sym;
		logic [31:0] sa;
	} entry_t;

	typedef struct packed {
		logic [31:0] pos;
		logic [32:0] len;
		logic [5:0]  sym;
		logic [31:0] mult;
		logic        last;
	} sample_t;

	logic clk, arst_n;
	logic psel, penable, pwrite;
	logic [2:0] paddr;
	logic [31:0] pwdata, prdata;
	logic pready;
	logic in_valid, in_ready;
	logic mode;
	logic [31:0] lcp_value, sa_value;
	logic [5:0] bwt_symbol;
	logic out_valid, out_ready;
	logic [31:0] sample_position, symbol_multiplicity;
	logic [32:0] sample_length;
	logic [5:0] sample_symbol;
	logic last_of_run;

	suffixient_sample_scan dut (.*);

	// predictor state; lengths are signed 34-bit
	logic [31:0] cfg_text_len;
	logic [6:0]  cfg_alpha;
	logic signed [33:0] c_len [NSYM];
	logic [32:0] c_pos [NSYM];
	logic signed [33:0] c_lcs [NSYM];
	logic        c_act [NSYM];
	logic [31:0] c_count [NSYM];
	logic signed [33:0] min_lcp;
	logic [5:0]  last_sym;
	logic [31:0] last_sa;
	logic        seen_first;

	sample_t pending_samples[$];
	int errors = 0;
	int send_idle = 34, recv_idle = 80;

	function automatic void clear_scan();
		for (int c = 0; c < NSYM; c++) begin
			c_len[c] = LEN_NONE;
			c_pos[c] = '0;
			c_lcs[c] = LEN_NONE;
			c_act[c] = 1'b0;
			c_count[c] = '0;
		end
		min_lcp = LEN_INF;
		last_sym = '0;
		last_sa = '0;
		seen_first = 1'b0;
	endfunction

	function automatic void sweep(logic signed [33:0] m);
		int lim;
		int first_idx;
		sample_t s;
		lim = (cfg_alpha > NSYM) ? NSYM : int'(cfg_alpha);
		first_idx = pending_samples.size();
		for (int c = 1; c < lim; c++) begin
			if (m < c_len[c]) begin
				if (c_act[c]) begin
					c_count[c] = c_count[c] + 1;
					s.pos = c_pos[c][31:0] - 32'd1;
					s.len = 33'(c_lcs[c] + 34'sd1);
					s.sym = 6'(c);
					s.mult = c_count[c];
					s.last = 1'b0;
					pending_samples = {pending_samples, s};
				end
				c_len[c] = m;
				c_pos[c] = '0;
				c_lcs[c] = m;
				c_act[c] = 1'b0;
			end
		end
		if (pending_samples.size() > first_idx)
			pending_samples[$].last = 1'b1;
	endfunction

	function automatic void raise(logic [5:0] s, logic signed [33:0] l, logic [31:0] sa);
		if (l > c_len[s]) begin
			c_len[s] = l;
			c_pos[s] = {1'b0, cfg_text_len - sa};
			c_act[s] = 1'b1;
		end
	endfunction

	function automatic void predict_samples(entry_t e);
		logic signed [33:0] l;
		l = $signed({2'b00, e.lcp});
		if (e.mode == MODE_FLUSH) begin
			sweep(LEN_NONE);
			clear_scan();
			return;
		end
		if (!seen_first) begin
			seen_first = 1'b1;
			last_sym = e.sym;
			last_sa = e.sa;
			return;
		end
		if (l < min_lcp)
			min_lcp = l;
		if (e.sym != last_sym) begin
			sweep(min_lcp);
			raise(last_sym, l, last_sa);
			raise(e.sym, l, e.sa);
			min_lcp = LEN_INF;
		end
		last_sym = e.sym;
		last_sa = e.sa;
	endfunction

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#400ms;
		$display("FAIL suffixient_sample_scan");
		$finish;
	end

	// sample checker
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle);
			if (out_valid && out_ready) begin
				sample_t got, exp;
				got = '{sample_position, sample_length, sample_symbol,
					symbol_multiplicity, last_of_run};
				if (pending_samples.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected sample %p", got);
				end else begin
					exp = pending_samples.pop_front();
					if (got !== exp) begin
						errors++;
						if (errors <= 10)
							$display("mismatch: exp %p got %p", exp, got);
					end
				end
			end
		end
	end

	task automatic apb_write(logic idx, logic [31:0] v);
		@(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= {idx, 2'b00}; pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		if (idx == REG_TEXT_LENGTH) cfg_text_len = v;
		else cfg_alpha = v[6:0];
	endtask

	task automatic send(entry_t e);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= e.mode; lcp_value <= e.lcp; bwt_symbol <= e.sym; sa_value <= e.sa;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predict_samples(e);
	endtask

	task automatic drain();
		int guard;
		guard = 0;
		in_valid <= 1'b0;
		while (pending_samples.size() != 0 && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		repeat (300) @(posedge clk);
	endtask

	// well-formed run: entries mostly from a small symbol set, ended by a flush
	task automatic random_text(int n, int nsym);
		entry_t e;
		for (int i = 0; i < n; i++) begin
			e.mode = MODE_ENTRY;
			e.sym = ($urandom_range(9) == 0) ? 6'($urandom) : 6'($urandom_range(nsym));
			e.lcp = ($urandom_range(19) == 0) ? $urandom : $urandom_range(12);
			e.sa = ($urandom_range(9) == 0) ? $urandom : $urandom_range(300);
			send(e);
		end
		e = '{MODE_FLUSH, $urandom, 6'($urandom), $urandom};
		send(e);
	endtask

	entry_t directed [] = '{
		'{MODE_ENTRY, 32'd0, 6'd1, 32'd3},
		'{MODE_ENTRY, 32'd2, 6'd2, 32'd1},
		'{MODE_ENTRY, 32'd1, 6'd2, 32'd5},
		'{MODE_ENTRY, 32'd0, 6'd1, 32'd0},
		'{MODE_ENTRY, 32'hFFFF_FFFF, 6'd63, 32'hFFFF_FFFF},
		'{MODE_ENTRY, 32'hFFFF_FFFF, 6'd0, 32'd0},
		'{MODE_ENTRY, 32'd5, 6'd63, 32'd7},
		'{MODE_ENTRY, 32'd3, 6'd62, 32'd9},
		'{MODE_ENTRY, 32'd0, 6'd0, 32'd2},
		'{MODE_FLUSH, 32'hFFFF_FFFF, 6'd63, 32'hFFFF_FFFF},
		'{MODE_ENTRY, 32'd7, 6'd5, 32'd4},
		'{MODE_ENTRY, 32'd7, 6'd5, 32'd6},
		'{MODE_ENTRY, 32'd4, 6'd6, 32'd8},
		'{MODE_ENTRY, 32'd2, 6'd5, 32'd1},
		'{MODE_ENTRY, 32'd1, 6'd6, 32'd2},
		'{MODE_FLUSH, 32'd0, 6'd0, 32'd0}
	};

	initial begin
		arst_n = 1'b0;
		psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
		in_valid = 0; mode = 0; lcp_value = '0; bwt_symbol = '0; sa_value = '0;
		cfg_text_len = 32'd1;
		cfg_alpha = 7'd64;
		clear_scan();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset configuration, then extremes
		foreach (directed[i]) send(directed[i]);
		drain();
		apb_write(REG_TEXT_LENGTH, 32'hFFFF_FFFF);
		apb_write(REG_ALPHABET_SIZE, 32'd127);
		foreach (directed[i]) send(directed[i]);
		drain();
		apb_write(REG_ALPHABET_SIZE, 32'd1);
		random_text(8, 5);
		drain();
		apb_write(REG_ALPHABET_SIZE, 32'd0);
		random_text(6, 5);
		drain();

		for (int ph = 0; ph < 3; ph++) begin
			if (ph == 1) begin send_idle = 80; recv_idle = 34; end
			if (ph == 2) begin send_idle = 0; recv_idle = 0; end
			apb_write(REG_TEXT_LENGTH, (ph == 0) ? 32'd1 : $urandom_range(500));
			apb_write(REG_ALPHABET_SIZE, (ph == 2) ? 32'd64 : $urandom_range(2, 12));
			for (int r = 0; r < 4; r++) random_text(25, 1 + $urandom_range(7));
			drain();
		end

		// samples still expected but never seen
		if (pending_samples.size() != 0)
			errors++;

		if (errors == 0)
			$display("PASS suffixient_sample_scan");
		else
			$display("FAIL suffixient_sample_scan");
		$finish;
	end
endmodule

// File: sim.f
+incdir+hdl
hdl/sss_pkg.sv
hdl/sss_ram.sv
hdl/sss_ctrl.sv
hdl/sss_dp.sv
hdl/suffixient_sample_scan.sv
test/testbench.sv
